>>> rtl/pwm_input_capture_meter_defines.svh
// Assertion macros shared by the PWM input-capture meter.
`ifndef PWM_INPUT_CAPTURE_METER_DEFINES_SVH
`define PWM_INPUT_CAPTURE_METER_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define PICM_ASSERT_SAME(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition implies a consequence in the following cycle.
`define PICM_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/pwmic_pkg.sv
// Shared types and constants of the PWM input-capture meter.
package pwmic_pkg;

  localparam int CAP_W       = 16;
  localparam int RATE_W      = 27;
  localparam int DUTY_W      = 7;
  localparam int CFG_DATA_W  = 27;
  localparam int CFG_INDEX_W = 2;
  localparam int DIV_W       = CAP_W + 1;
  localparam int DIV_STEPS   = RATE_W;
  localparam int STEP_W      = 5;
  localparam int DUTY_MAX    = 100;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_PRESCALE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RELOAD    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RATE      = 2'd2;

  typedef struct packed {
    logic [CAP_W-1:0] period;
    logic [CAP_W-1:0] high;
  } cap_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_HOLD
  } back_state_t;

endpackage

>>> rtl/pwmic_front.sv
// Capture front end: prescaler, main counter, edge detection and capture records.
module pwmic_front #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          pin_level,
  input  logic [pwmic_pkg::CAP_W-1:0]   prescale_minus_one,
  input  logic [pwmic_pkg::CAP_W-1:0]   reload_value,
  input  pwmic_pkg::q_status_t          q_status,
  output logic                          in_ready,
  output logic                          push,
  output pwmic_pkg::cap_rec_t           push_rec
);
  import pwmic_pkg::*;

  logic                   last_level;
  logic [CAP_W-1:0]       prescale_count;
  logic [COUNT_WIDTH-1:0] main_count;
  logic [CAP_W-1:0]       high_capture;

  logic [31:0]      count_ext;
  logic [CAP_W-1:0] count_low;
  logic             fire;
  logic             rise;
  logic             fall;

  assign count_ext = 32'(main_count);
  assign count_low = count_ext[CAP_W-1:0];
  assign in_ready  = !q_status.full;
  assign fire      = in_valid && in_ready;
  assign rise      = pin_level && !last_level;
  assign fall      = !pin_level && last_level;

  assign push            = fire && rise;
  assign push_rec.period = count_low;
  assign push_rec.high   = high_capture;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level     <= 1'b0;
      prescale_count <= '0;
      main_count     <= '0;
      high_capture   <= '0;
    end else if (fire) begin
      last_level <= pin_level;
      if (rise) begin
        // clear counter and prescaler instead of advancing
        main_count     <= '0;
        prescale_count <= '0;
      end else begin
        if (fall) high_capture <= count_low;
        if (prescale_count >= prescale_minus_one) begin
          prescale_count <= '0;
          if (count_ext == 32'(reload_value)) main_count <= '0;
          else main_count <= main_count + 1'b1;
        end else begin
          prescale_count <= prescale_count + 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/pwmic_fifo.sv
// Short capture queue between the front end and the divider back end.
module pwmic_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  pwmic_pkg::cap_rec_t  push_rec,
  input  logic                 pop,
  output pwmic_pkg::cap_rec_t  head,
  output pwmic_pkg::q_status_t q_status
);
  import pwmic_pkg::*;

  cap_rec_t               entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] fill;

  assign head           = entries[rd_ptr];
  assign q_status.full  = (fill == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign q_status.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> rtl/pwmic_back.sv
// Back end: bit-serial duty and frequency dividers and the result register.
module pwmic_back (
  input  logic                          clk,
  input  logic                          rst,
  input  pwmic_pkg::cap_rec_t           head,
  input  pwmic_pkg::q_status_t          q_status,
  input  logic [pwmic_pkg::RATE_W-1:0]  count_rate_hz,
  input  logic                          out_ready,
  output logic                          pop,
  output logic                          out_valid,
  output logic [pwmic_pkg::CAP_W-1:0]   period_count,
  output logic [pwmic_pkg::CAP_W-1:0]   high_count,
  output logic [pwmic_pkg::DUTY_W-1:0]  duty_percent,
  output logic [pwmic_pkg::RATE_W-1:0]  frequency_hz
);
  import pwmic_pkg::*;

  back_state_t       state;
  back_state_t       state_next;
  logic [STEP_W-1:0] step;
  logic [DIV_W-1:0]  divisor;
  logic [DIV_W-1:0]  rem_f;
  logic [DIV_W-1:0]  rem_d;
  logic [RATE_W-1:0] q_f;
  logic [RATE_W-1:0] q_d;
  logic [CAP_W-1:0]  cur_period;
  logic [CAP_W-1:0]  cur_high;

  logic              run;
  logic              out_load;
  logic [23:0]       duty_num;
  logic [DIV_W:0]    shf_f;
  logic [DIV_W:0]    shf_d;
  logic              ge_f;
  logic              ge_d;
  logic              zero_period;

  assign duty_num = 24'({1'b0, head.high} + DIV_W'(1)) * 24'd100;

  assign shf_f = {rem_f, q_f[RATE_W-1]};
  assign shf_d = {rem_d, q_d[RATE_W-1]};
  assign ge_f  = shf_f >= {1'b0, divisor};
  assign ge_d  = shf_d >= {1'b0, divisor};
  assign zero_period = (cur_period == '0);

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (!q_status.empty) state_next = BK_RUN;
      BK_RUN:  if (step == STEP_W'(DIV_STEPS - 1)) state_next = BK_HOLD;
      BK_HOLD: if (!out_valid || out_ready) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    run      = 1'b0;
    out_load = 1'b0;
    case (state)
      BK_IDLE: pop = !q_status.empty;
      BK_RUN:  run = 1'b1;
      BK_HOLD: out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else state <= state_next;
  end

  // divider datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_period <= head.period;
      cur_high   <= head.high;
      divisor    <= {1'b0, head.period} + DIV_W'(1);
      q_f        <= count_rate_hz;
      q_d        <= RATE_W'(duty_num);
      rem_f      <= '0;
      rem_d      <= '0;
      step       <= '0;
    end else if (run) begin
      step  <= step + 1'b1;
      q_f   <= {q_f[RATE_W-2:0], ge_f};
      q_d   <= {q_d[RATE_W-2:0], ge_d};
      rem_f <= ge_f ? DIV_W'(shf_f - {1'b0, divisor}) : shf_f[DIV_W-1:0];
      rem_d <= ge_d ? DIV_W'(shf_d - {1'b0, divisor}) : shf_d[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      period_count <= cur_period;
      high_count   <= cur_high;
      if (zero_period) begin
        duty_percent <= '0;
        frequency_hz <= '0;
      end else begin
        duty_percent <= (q_d > RATE_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX) : q_d[DUTY_W-1:0];
        frequency_hz <= q_f;
      end
    end
  end

endmodule

>>> rtl/pwm_input_capture_meter.sv
// Each rising-edge capture is queued, divided, then loaded into the result register.
// Throughput: one pin sample per cycle while the capture queue has room; the back end
// works one capture at a time through its one-bit-per-cycle 27-step dividers.
// Reset (rst, synchronous): counters, edge history and queue clear; registers
// return to prescale 71, reload 999, count rate 1000000 Hz.
module pwm_input_capture_meter #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // sample channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                pin_level,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pwmic_pkg::CAP_W-1:0]         period_count,
  output logic [pwmic_pkg::CAP_W-1:0]         high_count,
  output logic [pwmic_pkg::DUTY_W-1:0]        duty_percent,
  output logic [pwmic_pkg::RATE_W-1:0]        frequency_hz,
  // configuration write port
  input  logic                                cfg_write,
  input  logic [pwmic_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pwmic_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pwmic_pkg::*;
  `include "pwm_input_capture_meter_defines.svh"

  // configuration registers
  logic [CAP_W-1:0]  prescale_minus_one;
  logic [CAP_W-1:0]  reload_value;
  logic [RATE_W-1:0] count_rate_hz;

  // front to queue to back
  logic      push;
  cap_rec_t  push_rec;
  logic      pop;
  cap_rec_t  head;
  q_status_t q_status;

  // Take a register write on every enabled beat; drop unknown indexes.
  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_minus_one <= CAP_W'(71);
      reload_value       <= CAP_W'(999);
      count_rate_hz      <= RATE_W'(1000000);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PRESCALE: prescale_minus_one <= cfg_data[CAP_W-1:0];
        REG_RELOAD:   reload_value       <= cfg_data[CAP_W-1:0];
        REG_RATE:     count_rate_hz      <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: sample the pin each beat, count, and push a capture on each rising edge.
  pwmic_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .pin_level          (pin_level),
    .prescale_minus_one (prescale_minus_one),
    .reload_value       (reload_value),
    .q_status           (q_status),
    .in_ready           (in_ready),
    .push               (push),
    .push_rec           (push_rec)
  );

  // Queue: hold captures so sampling waits on a division in progress only when the queue is full.
  pwmic_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  // Back end: divide for duty and frequency, then present the result beat.
  pwmic_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_status      (q_status),
    .count_rate_hz (count_rate_hz),
    .out_ready     (out_ready),
    .pop           (pop),
    .out_valid     (out_valid),
    .period_count  (period_count),
    .high_count    (high_count),
    .duty_percent  (duty_percent),
    .frequency_hz  (frequency_hz)
  );

  `PICM_ASSERT_SAME(a_push_has_room, clk, rst, push, !q_status.full)
  `PICM_ASSERT_SAME(a_pop_not_empty, clk, rst, pop, !q_status.empty)
  `PICM_ASSERT_SAME(a_duty_range, clk, rst, out_valid, duty_percent <= DUTY_W'(DUTY_MAX))
  `PICM_ASSERT_SAME(a_zero_period, clk, rst, out_valid && (period_count == '0),
                    (duty_percent == '0) && (frequency_hz == '0))

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the PWM input-capture meter.
module tb_top;
  import pwmic_pkg::*;

  // Index with no register behind it; writes to it must be dropped.
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  // Cycles to hold off after the last result before a register write or the end,
  // so that the back end stands idle.
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 140;
  localparam int SRC_BUSY_PCT  = 19;
  localparam int SNK_BUSY_PCT  = 83;

  typedef struct packed {
    logic [CAP_W-1:0]  period;
    logic [CAP_W-1:0]  high;
    logic [DUTY_W-1:0] duty;
    logic [RATE_W-1:0] freq;
  } capture_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  data;
    logic                   lvl;
    logic                   typed;
    capture_t               want;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   pin_level = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [CAP_W-1:0]       period_count;
  logic [CAP_W-1:0]       high_count;
  logic [DUTY_W-1:0]      duty_percent;
  logic [RATE_W-1:0]      frequency_hz;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  pwm_input_capture_meter dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Capture predictor: own copy of the timer state and registers.
  // ---------------------------------------------------------------------------
  logic [CAP_W-1:0]  div_set  = 16'd71;
  logic [CAP_W-1:0]  wrap_at  = 16'd999;
  logic [RATE_W-1:0] rate_set = 27'd1000000;
  logic              lvl_q    = 1'b0;
  logic [CAP_W-1:0]  div_cnt  = '0;
  logic [CAP_W-1:0]  tick_cnt = '0;
  logic [CAP_W-1:0]  hi_cap   = '0;

  capture_t pending_caps[$];
  int       mismatch_count = 0;
  int       src_idle_pct = 0;
  int       snk_idle_pct = 0;

  // Advance the timer by one tick; return 1 with the capture on a rising edge.
  function automatic bit meter_tick(input logic lvl, output capture_t cap);
    longint unsigned duty_q;
    bit rose;
    rose = lvl && !lvl_q;
    cap  = '0;
    if (rose) begin
      cap.period = tick_cnt;
      cap.high   = hi_cap;
      // Zero period leaves duty and frequency at zero.
      if (tick_cnt != 0) begin
        duty_q = ((longint'(hi_cap) + 1) * 100) / (longint'(tick_cnt) + 1);
        if (duty_q > DUTY_MAX) duty_q = DUTY_MAX;
        cap.duty = duty_q[DUTY_W-1:0];
        cap.freq = RATE_W'(longint'(rate_set) / (longint'(tick_cnt) + 1));
      end
      // Rising edge clears counter and prescaler instead of advancing them.
      tick_cnt = '0;
      div_cnt  = '0;
    end else begin
      if (!lvl && lvl_q) hi_cap = tick_cnt;
      // Prescaler at or above its setting wraps; counter above reload keeps going up.
      if (div_cnt >= div_set) begin
        div_cnt  = '0;
        tick_cnt = (tick_cnt == wrap_at) ? '0 : tick_cnt + 1'b1;
      end else begin
        div_cnt = div_cnt + 1'b1;
      end
    end
    lvl_q = lvl;
    return rose;
  endfunction

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: drop ready at random, compare each accepted beat at the
  // falling edge, where everything driven at the rising edge has settled.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  always @(negedge clk) begin : check_results
    capture_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_caps.size() == 0) begin
        flag_mismatch("unexpected result beat, period", period_count, 0);
      end else begin
        want = pending_caps.pop_front();
        if (period_count !== want.period)
          flag_mismatch("period_count", period_count, want.period);
        if (high_count !== want.high)
          flag_mismatch("high_count", high_count, want.high);
        if (duty_percent !== want.duty)
          flag_mismatch("duty_percent", duty_percent, want.duty);
        if (frequency_hz !== want.freq)
          flag_mismatch("frequency_hz", frequency_hz, want.freq);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sample side. Every task returns just after a rising edge.
  // ---------------------------------------------------------------------------

  // Offer one pin sample; record the expected capture once the beat is taken.
  // A typed capture overrides the predicted one for hand-checked rows.
  task automatic send_sample(input logic lvl, input logic typed, input capture_t typed_cap);
    capture_t cap;
    bit taken;
    bit made;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    pin_level <= lvl;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ready;
      if (taken) begin
        made = meter_tick(lvl, cap);
        if (typed) pending_caps.push_back(typed_cap);
        else if (made) pending_caps.push_back(cap);
      end
      @(posedge clk);
    end
  endtask

  // Park the sender and hold until every expected capture has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_caps.size() != 0) @(posedge clk);
  endtask

  // Write a register once the block is idle; no read-back.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_PRESCALE: div_set  = data[CAP_W-1:0];
      REG_RELOAD:   wrap_at  = data[CAP_W-1:0];
      REG_RATE:     rate_set = data[RATE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // One random phase: mostly whole PWM periods with random high and low times,
  // some short bursts of random samples, and some long flat runs that let the counter climb.
  task automatic run_phase(input logic [CAP_W-1:0] div, input logic [CAP_W-1:0] wrap,
                           input logic [RATE_W-1:0] rate, input int src_pct,
                           input int snk_pct, input int max_len, input bit hold_mid);
    int sent;
    int pick;
    int hi_len;
    int lo_len;
    int run_len;
    logic lvl;
    bit held;
    write_reg(REG_PRESCALE, CFG_DATA_W'(div));
    write_reg(REG_RELOAD, CFG_DATA_W'(wrap));
    write_reg(REG_RATE, CFG_DATA_W'(rate));
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    sent = 0;
    held = 1'b0;
    while (sent < PHASE_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        hi_len = $urandom_range(1, max_len);
        lo_len = $urandom_range(1, max_len);
        repeat (hi_len) send_sample(1'b1, 1'b0, '0);
        repeat (lo_len) send_sample(1'b0, 1'b0, '0);
        sent += hi_len + lo_len;
      end else if (pick < 93) begin
        run_len = $urandom_range(1, 6);
        repeat (run_len) send_sample(1'($urandom_range(0, 1)), 1'b0, '0);
        sent += run_len;
      end else begin
        run_len = $urandom_range(15, 50);
        lvl = 1'($urandom_range(0, 1));
        repeat (run_len) send_sample(lvl, 1'b0, '0);
        sent += run_len;
      end
      // Starve the block once mid-phase until the result queue has emptied.
      if (hold_mid && !held && sent >= PHASE_ITEMS / 2) begin
        drain_results();
        held = 1'b1;
      end
    end
    // End high so the counter stands well up when the next settings land.
    run_len = $urandom_range(20, 80);
    repeat (run_len) send_sample(1'b1, 1'b0, '0);
  endtask

  function automatic stim_row_t sample_row(input logic lvl);
    stim_row_t r;
    r = '0;
    r.kind = ROW_SAMPLE;
    r.lvl  = lvl;
    return r;
  endfunction

  function automatic stim_row_t checked_row(input logic lvl, input int per, input int hi,
                                            input int duty, input int freq);
    stim_row_t r;
    r = sample_row(lvl);
    r.typed = 1'b1;
    r.want  = '{period: CAP_W'(per), high: CAP_W'(hi), duty: DUTY_W'(duty),
                freq: RATE_W'(freq)};
    return r;
  endfunction

  function automatic stim_row_t write_row(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    stim_row_t dir_rows[$];
    // Hand-checked opener: high first sample is a rising edge, a plain period,
    // duty saturation after a reload wrap, count rate extremes, a write to an
    // unused index, and zero period from a zero reload.
    dir_rows = '{
      checked_row(1'b1, 0, 0, 0, 0),
      write_row(REG_PRESCALE, 27'd0),
      sample_row(1'b1), sample_row(1'b1), sample_row(1'b0), sample_row(1'b0),
      checked_row(1'b1, 4, 2, 60, 200000),
      write_row(REG_RELOAD, 27'd3),
      sample_row(1'b1), sample_row(1'b1), sample_row(1'b1),
      sample_row(1'b0), sample_row(1'b0),
      checked_row(1'b1, 1, 3, 100, 500000),
      write_row(REG_RATE, 27'd72000000),
      sample_row(1'b0),
      checked_row(1'b1, 1, 0, 50, 36000000),
      write_row(REG_RATE, 27'd0),
      write_row(REG_UNUSED, 27'h7FFFFFF),
      sample_row(1'b0),
      checked_row(1'b1, 1, 0, 50, 0),
      write_row(REG_RELOAD, 27'd0),
      sample_row(1'b0),
      checked_row(1'b1, 0, 0, 0, 0)
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_sample(dir_rows[i].lvl, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Sender busy, receiver mostly stalled.
    run_phase(16'd0, 16'd65535, 27'd72000000, SRC_BUSY_PCT, SNK_BUSY_PCT, 12, 1'b1);
    // Reload drops below the count left by the tail above.
    run_phase(16'd1, 16'd7, 27'd1000000, SRC_BUSY_PCT, SNK_BUSY_PCT, 12, 1'b0);
    // Now the other way round; slowest prescale, lowest nonzero rate.
    run_phase(16'd65535, 16'd999, 27'd1, SNK_BUSY_PCT, SRC_BUSY_PCT, 12, 1'b0);
    // Prescale drops below the prescaler count left by the tail above.
    run_phase(16'd3, 16'd0, 27'd5000, SNK_BUSY_PCT, SRC_BUSY_PCT, 12, 1'b0);
    // No idling from here on.
    run_phase(16'd0, 16'd200, 27'h7FFFFFF, 0, 0, 30, 1'b0);
    run_phase(16'($urandom_range(0, 3)), 16'($urandom_range(1, 300)),
              27'($urandom_range(1, 72000000)), 0, 0, 20, 1'b0);
    run_phase(16'($urandom_range(0, 9)), 16'($urandom_range(0, 65535)),
              27'($urandom_range(1, 72000000)), 0, 0, 40, 1'b0);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("pwm_input_capture_meter test passed");
    end else begin
      $display("pwm_input_capture_meter test failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #3000000;
    $display("pwm_input_capture_meter test failed");
    $finish;
  end

endmodule
